/* src/bets_pkg.sv */
`timescale 1ns / 1ps
// bets_pkg: shared constants, codes and types of the bulb exposure timer
// used by bets_slot_bank, bets_exposure and bulb_exposure_timer_with_slots_core
package bets_pkg;

    // slot bank size and reporting cap
    localparam int SLOTS   = 8;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_RES = 8;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    // timing constants
    localparam int SYNC_WAIT = 2000;
    localparam int MS_PER_S  = 1000;
    localparam int MS_W      = 11;
    localparam int MS_WRAP   = (1 << MS_W) - 1;

    // field widths
    localparam int KIND_W   = 3;
    localparam int EV_W     = 3;
    localparam int DUR_W    = 24;
    localparam int DELAY_W  = 16;
    localparam int TAG_W    = 8;
    localparam int SLOTF_W  = 3;
    localparam int CNT32_W  = 32;
    localparam int SKIP_W   = 8;
    localparam int CHG_W    = SKIP_W + 1;
    localparam int REM_W    = 26;
    localparam int SREM_W   = 24;
    localparam int OFS_W    = 16;

    // stream and config port widths
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 112;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_START  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ARM    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    // result events
    localparam logic [EV_W-1:0] EV_STATUS = 3'd0;
    localparam logic [EV_W-1:0] EV_OPEN   = 3'd1;
    localparam logic [EV_W-1:0] EV_CLOSE  = 3'd2;
    localparam logic [EV_W-1:0] EV_SWITCH = 3'd3;
    localparam logic [EV_W-1:0] EV_FIRE   = 3'd4;
    localparam logic [EV_W-1:0] EV_DROP   = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PC_SYNC    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_NEG = 3'd4;

    // configuration seen by the exposure logic
    typedef struct packed {
        logic               sync_mode;
        logic               pc_sync_required;
        logic [OFS_W-1:0]   bulb_end_offset;
        logic [OFS_W-1:0]   bulb_offset;
        logic               offset_negative;
    } bets_cfg_t;

    // exposure step request
    typedef struct packed {
        logic               tick;
        logic               start;
        logic               cancel;
        logic               sync_level;
        logic [DUR_W-1:0]   duration;
    } bets_exp_ctrl_t;

    // exposure step outcome and state flags
    typedef struct packed {
        logic               hit;
        logic [EV_W-1:0]    ev;
        logic               running;
        logic               sync_flag;
    } bets_exp_stat_t;

    // slot bank control from the sequencer
    typedef struct packed {
        logic               rd_en;
        logic [SLOT_W-1:0]  rd_addr;
        logic               commit;
        logic [SLOT_W-1:0]  idx;
        logic [CHG_W-1:0]   charge;
        logic               arm;
        logic [DELAY_W-1:0] arm_delay;
        logic [TAG_W-1:0]   arm_tag;
    } bets_slot_ctrl_t;

    // slot bank status to the sequencer
    typedef struct packed {
        logic               fire;
        logic [TAG_W-1:0]   tag;
        logic               any_free;
        logic [SLOT_W-1:0]  free_idx;
    } bets_slot_stat_t;

endpackage

/* src/bulb_exposure_timer_with_slots_core.sv */
`timescale 1ns / 1ps
// bulb_exposure_timer_with_slots_core: top level, sequencer, counters, output word
// depends on bets_pkg, bets_exposure, bets_slot_bank
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    tuser: kind; tdata: sync_level, duration,
//                                       delay, action_id
//  m_*      out  m_tvalid / m_tready    tuser: event_res; tlast: last; tdata: fired_action,
//                                       fired_slot, event_count, total_ms, seconds_count,
//                                       exposing, sync_used
//  cfg_*    in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a tick that scans the slots passes them one per cycle, while the scan is not stalled,
// through the shared charge unit and its slot memory read port.
// every other word, including exposure ticks that hit, goes from exec straight to flush.
// a full output register stalls the scan only when a second fired slot is found,
// and holds the final word in the flush state until the register frees.
// rst_n clears counters, exposure state, busy bits and configuration at once.
module bulb_exposure_timer_with_slots_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bets_pkg::IN_TDATA_W-1:0]    s_tdata,   // sync_level, duration, delay,
                                                          // action_id, zero pad
    input  logic [bets_pkg::KIND_W-1:0]        s_tuser,   // kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bets_pkg::OUT_TDATA_W-1:0]   m_tdata,   // fired_action, fired_slot,
                                                          // event_count, total_ms,
                                                          // seconds_count, exposing,
                                                          // sync_used, zero pad
    output logic [bets_pkg::EV_W-1:0]          m_tuser,   // event_res
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bets_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bets_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_PRIME = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [2:0] state_reg, state_next;

    // captured input word
    logic [bets_pkg::KIND_W-1:0]  kind_reg;
    logic                         lvl_reg;
    logic [bets_pkg::DUR_W-1:0]   dur_reg;
    logic [bets_pkg::DELAY_W-1:0] delay_reg;
    logic [bets_pkg::TAG_W-1:0]   act_reg;

    // counters
    logic [bets_pkg::MS_W-1:0]    ms_reg,      ms_next;
    logic [bets_pkg::CNT32_W-1:0] event_reg,   event_next;
    logic [bets_pkg::CNT32_W-1:0] sec_reg,     sec_next;
    logic [bets_pkg::CNT32_W-1:0] total_reg,   total_next;
    logic [bets_pkg::SKIP_W-1:0]  skipped_reg, skipped_next;

    // scan and pending result
    logic [bets_pkg::SLOT_W-1:0]  idx_reg,      idx_next;
    logic [bets_pkg::CNT_W-1:0]   rep_cnt_reg,  rep_cnt_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [bets_pkg::EV_W-1:0]    pend_ev_reg,  pend_ev_next;
    logic [bets_pkg::TAG_W-1:0]   pend_act_reg, pend_act_next;
    logic [bets_pkg::SLOTF_W-1:0] pend_slot_reg, pend_slot_next;

    // configuration
    bets_pkg::bets_cfg_t cfg_reg;

    // output register
    logic                           out_valid_reg;
    logic [bets_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic [bets_pkg::EV_W-1:0]      out_ev_reg;
    logic                           out_last_reg;

    bets_pkg::bets_exp_ctrl_t  exp_ctrl;
    bets_pkg::bets_exp_stat_t  exp_stat;
    bets_pkg::bets_slot_ctrl_t slot_ctrl;
    bets_pkg::bets_slot_stat_t slot_stat;

    logic                         s_accept;
    logic                         out_free;
    logic                         scan_report;
    logic                         scan_adv;
    logic                         out_push;
    logic                         out_final;
    logic                         out_load;
    logic [bets_pkg::MS_W-1:0]    ms_inc;
    logic [bets_pkg::CNT32_W-1:0] total_inc;
    logic                         last_slot;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bets_pkg::CFG_SYNC_MODE:  cfg_reg.sync_mode        <= cfg_data[0];
                bets_pkg::CFG_PC_SYNC:    cfg_reg.pc_sync_required <= cfg_data[0];
                bets_pkg::CFG_END_OFFSET: cfg_reg.bulb_end_offset  <= cfg_data;
                bets_pkg::CFG_OFFSET:     cfg_reg.bulb_offset      <= cfg_data;
                bets_pkg::CFG_OFFSET_NEG: cfg_reg.offset_negative  <= cfg_data[0];
                default:                  cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // input word capture
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            kind_reg  <= s_tuser;
            lvl_reg   <= s_tdata[0];
            dur_reg   <= s_tdata[24:1];
            delay_reg <= s_tdata[40:25];
            act_reg   <= s_tdata[48:41];
        end
    end

    // exposure unit
    assign exp_ctrl.tick       = (state_reg == ST_EXEC) && (kind_reg == bets_pkg::KIND_TICK);
    assign exp_ctrl.start      = (state_reg == ST_EXEC) && (kind_reg == bets_pkg::KIND_START);
    assign exp_ctrl.cancel     = (state_reg == ST_EXEC) && (kind_reg == bets_pkg::KIND_CANCEL);
    assign exp_ctrl.sync_level = lvl_reg;
    assign exp_ctrl.duration   = dur_reg;

    bets_exposure u_exposure (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .ctrl  (exp_ctrl),
        .stat  (exp_stat)
    );

    // slot scan control
    assign last_slot   = (idx_reg == bets_pkg::SLOT_W'(bets_pkg::SLOTS - 1));
    assign scan_report = slot_stat.fire && (rep_cnt_reg < bets_pkg::CNT_W'(bets_pkg::MAX_RES));
    assign scan_adv    = !(scan_report && pend_valid_reg && !out_free);

    assign slot_ctrl.rd_en     = (state_reg == ST_PRIME) || (state_reg == ST_SCAN);
    assign slot_ctrl.rd_addr   = (state_reg == ST_PRIME) ? '0
                               : (scan_adv ? (idx_reg + 1'b1) : idx_reg);
    assign slot_ctrl.commit    = (state_reg == ST_SCAN) && scan_adv;
    assign slot_ctrl.idx       = idx_reg;
    assign slot_ctrl.charge    = bets_pkg::CHG_W'(skipped_reg) + 1'b1;
    assign slot_ctrl.arm       = (state_reg == ST_EXEC) && (kind_reg == bets_pkg::KIND_ARM)
                               && slot_stat.any_free;
    assign slot_ctrl.arm_delay = delay_reg;
    assign slot_ctrl.arm_tag   = act_reg;

    bets_slot_bank u_slot_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (slot_ctrl),
        .stat  (slot_stat)
    );

    // millisecond and total counter steps
    assign ms_inc    = ms_reg + 1'b1;
    assign total_inc = (ms_reg == bets_pkg::MS_W'(bets_pkg::MS_WRAP))
                     ? (total_reg - bets_pkg::CNT32_W'(bets_pkg::MS_WRAP))
                     : (total_reg + 1'b1);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        ms_next         = ms_reg;
        event_next      = event_reg;
        sec_next        = sec_reg;
        total_next      = total_reg;
        skipped_next    = skipped_reg;
        idx_next        = idx_reg;
        rep_cnt_next    = rep_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_ev_next    = pend_ev_reg;
        pend_act_next   = pend_act_reg;
        pend_slot_next  = pend_slot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                pend_valid_next = 1'b0;
                pend_ev_next    = bets_pkg::EV_STATUS;
                pend_act_next   = '0;
                pend_slot_next  = '0;
                state_next      = ST_FLUSH;
                unique case (kind_reg)
                    bets_pkg::KIND_TICK:
                    begin
                        event_next = event_reg + 1'b1;
                        total_next = total_inc;
                        ms_next    = ms_inc;
                        if (exp_stat.hit)
                        begin
                            skipped_next = skipped_reg + 1'b1;
                            pend_ev_next = exp_stat.ev;
                        end
                        else
                        begin
                            // seconds rollover, then scan the slots
                            if (ms_inc >= bets_pkg::MS_W'(bets_pkg::MS_PER_S))
                            begin
                                ms_next  = ms_inc - bets_pkg::MS_W'(bets_pkg::MS_PER_S);
                                sec_next = sec_reg + 1'b1;
                            end
                            idx_next     = '0;
                            rep_cnt_next = '0;
                            state_next   = ST_PRIME;
                        end
                    end
                    bets_pkg::KIND_ARM:
                    begin
                        if (slot_stat.any_free)
                        begin
                            pend_slot_next = bets_pkg::SLOTF_W'(slot_stat.free_idx);
                        end
                        else
                        begin
                            pend_ev_next = bets_pkg::EV_DROP;
                        end
                    end
                    bets_pkg::KIND_CLEAR:
                    begin
                        event_next = '0;
                    end
                    default:
                    begin
                        // start, cancel and unused kinds give a status word
                        pend_ev_next = bets_pkg::EV_STATUS;
                    end
                endcase
            end
            ST_PRIME:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_adv)
                begin
                    if (scan_report)
                    begin
                        rep_cnt_next    = rep_cnt_reg + 1'b1;
                        pend_valid_next = 1'b1;
                        pend_ev_next    = bets_pkg::EV_FIRE;
                        pend_act_next   = slot_stat.tag;
                        pend_slot_next  = bets_pkg::SLOTF_W'(idx_reg);
                    end
                    if (last_slot)
                    begin
                        skipped_next = '0;
                        state_next   = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ms_reg         <= '0;
            event_reg      <= '0;
            sec_reg        <= '0;
            total_reg      <= '0;
            skipped_reg    <= '0;
            idx_reg        <= '0;
            rep_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            pend_ev_reg    <= bets_pkg::EV_STATUS;
            pend_act_reg   <= '0;
            pend_slot_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ms_reg         <= ms_next;
            event_reg      <= event_next;
            sec_reg        <= sec_next;
            total_reg      <= total_next;
            skipped_reg    <= skipped_next;
            idx_reg        <= idx_next;
            rep_cnt_reg    <= rep_cnt_next;
            pend_valid_reg <= pend_valid_next;
            pend_ev_reg    <= pend_ev_next;
            pend_act_reg   <= pend_act_next;
            pend_slot_reg  <= pend_slot_next;
        end
    end

    // output register: earlier fired slot on a new find, pending word at flush
    assign out_push  = (state_reg == ST_SCAN) && scan_report && pend_valid_reg && out_free;
    assign out_final = (state_reg == ST_FLUSH) && out_free;
    assign out_load  = out_push || out_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ev_reg   <= pend_ev_reg;
            out_last_reg <= out_final;
            out_data_reg <= {3'b000, exp_stat.sync_flag, exp_stat.running, sec_reg,
                             total_reg, event_reg, pend_slot_reg, pend_act_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ev_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // a word waits in the pending stage exactly when a slot has been reported
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (pend_valid_reg == (rep_cnt_reg != '0)))
        else $error("core: pending word out of step with report count");

    // never more fired slots reported than the cap
    assert property (@(posedge clk) disable iff (!rst_n)
        rep_cnt_reg <= bets_pkg::CNT_W'(bets_pkg::MAX_RES))
        else $error("core: report count above cap");

    // the flush always closes the run with a marked final word
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FLUSH) && out_free) |=> (m_tvalid && m_tlast))
        else $error("core: flush did not present a final word");
`endif

endmodule

/* src/bets_slot_bank.sv */
`timescale 1ns / 1ps
// bets_slot_bank: delay slot memories, busy bits and the shared charge unit
// depends on bets_pkg
module bets_slot_bank (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bets_pkg::bets_slot_ctrl_t ctrl,
    output bets_pkg::bets_slot_stat_t stat
);

    logic [bets_pkg::DELAY_W-1:0] time_mem [bets_pkg::SLOTS];
    logic [bets_pkg::TAG_W-1:0]   tag_mem  [bets_pkg::SLOTS];
    logic [bets_pkg::DELAY_W-1:0] time_rd_reg;
    logic [bets_pkg::TAG_W-1:0]   tag_rd_reg;
    logic [bets_pkg::SLOTS-1:0]   busy_reg;
    logic [bets_pkg::SLOTS-1:0]   busy_next;

    logic [bets_pkg::DELAY_W-1:0] charge_ext;
    logic [bets_pkg::DELAY_W-1:0] time_left;
    logic                         fire;
    logic [bets_pkg::SLOT_W-1:0]  free_idx;
    logic                         time_we;
    logic [bets_pkg::SLOT_W-1:0]  time_wa;
    logic [bets_pkg::DELAY_W-1:0] time_wd;

    // shared charge unit: one subtract and compare for the slot under scan
    assign charge_ext = bets_pkg::DELAY_W'(ctrl.charge);
    assign time_left  = time_rd_reg - charge_ext;
    assign fire       = busy_reg[ctrl.idx] && (time_rd_reg <= charge_ext);

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = bets_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_idx = bets_pkg::SLOT_W'(i);
            end
        end
    end

    // single write port: arm or scan write-back
    always_comb
    begin
        time_we = 1'b0;
        time_wa = ctrl.idx;
        time_wd = time_left;
        if (ctrl.arm)
        begin
            time_we = 1'b1;
            time_wa = free_idx;
            time_wd = ctrl.arm_delay;
        end
        else if (ctrl.commit && busy_reg[ctrl.idx] && !fire)
        begin
            time_we = 1'b1;
        end
    end

    // slot memories, registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            time_rd_reg <= time_mem[ctrl.rd_addr];
            tag_rd_reg  <= tag_mem[ctrl.rd_addr];
        end
        if (time_we)
        begin
            time_mem[time_wa] <= time_wd;
        end
        if (ctrl.arm)
        begin
            tag_mem[free_idx] <= ctrl.arm_tag;
        end
    end

    // busy bits
    always_comb
    begin
        busy_next = busy_reg;
        if (ctrl.arm)
        begin
            busy_next[free_idx] = (ctrl.arm_delay != '0);
        end
        else if (ctrl.commit && fire)
        begin
            busy_next[ctrl.idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    assign stat.fire     = fire;
    assign stat.tag      = tag_rd_reg;
    assign stat.any_free = ~&busy_reg;
    assign stat.free_idx = free_idx;

`ifndef SYNTHESIS
    // arming and scan write-back never share the write port
    assert property (@(posedge clk) disable iff (!rst_n) ctrl.arm |-> !ctrl.commit)
        else $error("slot bank: arm during scan commit");
`endif

endmodule

/* src/bets_exposure.sv */
`timescale 1ns / 1ps
// bets_exposure: bulb exposure state and its per-tick step
// depends on bets_pkg
module bets_exposure (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bets_pkg::bets_cfg_t      cfg,
    input  bets_pkg::bets_exp_ctrl_t ctrl,
    output bets_pkg::bets_exp_stat_t stat
);

    logic                                pending_reg,   pending_next;
    logic                                running_reg,   running_next;
    logic                                sync_flag_reg, sync_flag_next;
    logic signed [bets_pkg::REM_W-1:0]   rem_reg,       rem_next;
    logic [bets_pkg::SREM_W-1:0]         sync_rem_reg,  sync_rem_next;

    logic signed [bets_pkg::REM_W-1:0]   rem_dec;
    logic signed [bets_pkg::REM_W-1:0]   end_ofs;
    logic signed [bets_pkg::REM_W-1:0]   ofs;
    logic signed [bets_pkg::REM_W-1:0]   wait_ms;
    logic signed [bets_pkg::REM_W-1:0]   rem_open;
    logic signed [bets_pkg::REM_W-1:0]   rem_trim;
    logic                                sync_arm;
    logic                                hit;
    logic [bets_pkg::EV_W-1:0]           ev;

    // arithmetic for opening and counting down
    assign sync_arm = cfg.sync_mode && !ctrl.sync_level;
    assign end_ofs  = $signed(bets_pkg::REM_W'(cfg.bulb_end_offset));
    assign ofs      = $signed(bets_pkg::REM_W'(cfg.bulb_offset));
    assign wait_ms  = (sync_arm && cfg.pc_sync_required)
                    ? $signed(bets_pkg::REM_W'(bets_pkg::SYNC_WAIT)) : '0;
    assign rem_open = cfg.offset_negative ? (rem_reg + wait_ms - ofs)
                                          : (rem_reg + wait_ms + ofs);
    assign rem_trim = rem_reg - end_ofs;
    assign rem_dec  = rem_reg - $signed(bets_pkg::REM_W'(1));

    // exposure step
    always_comb
    begin
        pending_next   = pending_reg;
        running_next   = running_reg;
        sync_flag_next = sync_flag_reg;
        rem_next       = rem_reg;
        sync_rem_next  = sync_rem_reg;
        hit            = 1'b0;
        ev             = bets_pkg::EV_STATUS;
        if (ctrl.start)
        begin
            running_next = 1'b0;
            rem_next     = $signed(bets_pkg::REM_W'(ctrl.duration));
            pending_next = 1'b1;
        end
        else if (ctrl.cancel)
        begin
            running_next = 1'b0;
            rem_next     = '0;
            pending_next = 1'b0;
        end
        else if (ctrl.tick)
        begin
            if (pending_reg)
            begin
                // open the shutter
                if (sync_arm && (rem_reg > end_ofs))
                begin
                    sync_rem_next = rem_trim[bets_pkg::SREM_W-1:0];
                end
                else
                begin
                    sync_rem_next = '0;
                end
                pending_next = 1'b0;
                running_next = 1'b1;
                rem_next     = rem_open;
                hit          = 1'b1;
                ev           = bets_pkg::EV_OPEN;
            end
            else if (running_reg)
            begin
                rem_next = rem_dec;
                if (rem_dec[bets_pkg::REM_W-1] || (rem_dec == '0))
                begin
                    // time is up
                    running_next = 1'b0;
                    if (sync_rem_reg != '0)
                    begin
                        sync_flag_next = 1'b0;
                    end
                    hit = 1'b1;
                    ev  = bets_pkg::EV_CLOSE;
                end
                else if ((sync_rem_reg != '0) && ctrl.sync_level)
                begin
                    // flash sync seen: finish on the sync duration
                    rem_next       = $signed(bets_pkg::REM_W'(sync_rem_reg));
                    sync_rem_next  = '0;
                    sync_flag_next = 1'b1;
                    hit            = 1'b1;
                    ev             = bets_pkg::EV_SWITCH;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            running_reg   <= 1'b0;
            sync_flag_reg <= 1'b0;
            rem_reg       <= '0;
            sync_rem_reg  <= '0;
        end
        else
        begin
            pending_reg   <= pending_next;
            running_reg   <= running_next;
            sync_flag_reg <= sync_flag_next;
            rem_reg       <= rem_next;
            sync_rem_reg  <= sync_rem_next;
        end
    end

    assign stat.hit       = hit;
    assign stat.ev        = ev;
    assign stat.running   = running_reg;
    assign stat.sync_flag = sync_flag_reg;

`ifndef SYNTHESIS
    // an exposure is either waiting to open or running, never both
    assert property (@(posedge clk) disable iff (!rst_n) !(pending_reg && running_reg))
        else $error("exposure: pending and running together");
`endif

endmodule
